/* src/ubd_pkg.sv */
package ubd_pkg;

    localparam int unsigned BAUD_W   = 20;
    localparam int unsigned CLK_W    = 32;
    localparam int unsigned DIV_W    = 22;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    // rounded quotient numerator: 4*clk + baud/2
    localparam int unsigned NUM1_W   = CLK_W + 3;
    // achieved rate numerator: 4*clk
    localparam int unsigned NUM2_W   = CLK_W + 2;

    localparam logic [BAUD_W-1:0] BAUD_MIN   = BAUD_W'(300);
    localparam logic [BAUD_W-1:0] BAUD_MAX   = BAUD_W'(1000000);
    localparam logic [NUM1_W-1:0] DIV_MIN    = NUM1_W'(64);
    localparam logic [NUM1_W-1:0] DIV_MAX    = NUM1_W'(22'h3fffff);
    localparam int unsigned       ERR_PCT    = 2;
    localparam int unsigned       PCT_SCALE  = 100;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = CLK_W'(48000000);

    // register indexes
    localparam logic REG_CLOCK_HZ = 1'b0;

endpackage

/* src/ubd_div_pipe.sv */
module ubd_div_pipe #(
    parameter int unsigned NUM_W = 35,
    parameter int unsigned DEN_W = 20,
    parameter int unsigned SB_W  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [SB_W-1:0]  sb_out
);

    // restoring divider, one quotient bit per stage
    logic             v_reg   [0:NUM_W];
    logic [NUM_W-1:0] nm_reg  [0:NUM_W];
    logic [NUM_W-1:0] q_reg   [0:NUM_W];
    logic [DEN_W-1:0] rem_reg [0:NUM_W];
    logic [DEN_W-1:0] den_reg [0:NUM_W];
    logic [SB_W-1:0]  sb_reg  [0:NUM_W];

    always_comb
    begin
        v_reg[0]   = in_valid;
        nm_reg[0]  = num;
        q_reg[0]   = '0;
        rem_reg[0] = '0;
        den_reg[0] = den;
        sb_reg[0]  = sb_in;
    end

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_stage
            logic [DEN_W:0]   trial;
            logic             take;
            logic [DEN_W:0]   diff;
            logic [DEN_W-1:0] rem_next;

            always_comb
            begin
                trial    = {rem_reg[i], nm_reg[i][NUM_W-1]};
                take     = trial >= {1'b0, den_reg[i]};
                diff     = trial - {1'b0, den_reg[i]};
                rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nm_reg[i+1]  <= {nm_reg[i][NUM_W-2:0], 1'b0};
                    q_reg[i+1]   <= {q_reg[i][NUM_W-2:0], take};
                    rem_reg[i+1] <= rem_next;
                    den_reg[i+1] <= den_reg[i];
                    sb_reg[i+1]  <= sb_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NUM_W];
    assign quo       = q_reg[NUM_W];
    assign sb_out    = sb_reg[NUM_W];

endmodule

/* src/uart_baud_divisor_check.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall | baud_rate[19:0]
// out     | output    | out_valid/out_stall | valid_res, divisor[21:0]
// cfg     | input     | APB psel/penable    | clock_hz at paddr 0
//
// One transaction enters per cycle unless the pipe is stalled. Each passes through
// a 35-stage divider for the rounded divisor, a 34-stage divider for the
// achieved rate, and the output register holding the error check.
// rst_n clears all valid bits and sets clock_hz to 48000000.
// out_stall with a result waiting freezes the whole pipe; in_stall follows.
module uart_baud_divisor_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ubd_pkg::BAUD_W-1:0] baud_rate,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       valid_res,
    output logic [ubd_pkg::DIV_W-1:0]  divisor,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ubd_pkg::ADDR_W-1:0] paddr,
    input  logic [ubd_pkg::DATA_W-1:0] pwdata,
    output logic [ubd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ubd_pkg::*;

    localparam int unsigned SB1_W = CLK_W + BAUD_W + 1;
    localparam int unsigned SB2_W = BAUD_W + DIV_W + 1;

    logic [CLK_W-1:0] clock_hz_reg;
    logic             en;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLOCK_HZ) ? clock_hz_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_CLOCK_HZ)
        begin
            clock_hz_reg <= pwdata;
        end
    end

    // front checks and first divider operands
    logic              rej_in;
    logic [NUM1_W-1:0] num1;
    logic [SB1_W-1:0]  sb1_in;

    always_comb
    begin
        rej_in = (baud_rate < BAUD_MIN) || (baud_rate > BAUD_MAX) ||
                 ({2'b00, clock_hz_reg} < {2'b00, baud_rate, 4'b0000});
        num1   = {1'b0, clock_hz_reg, 2'b00} + NUM1_W'(baud_rate >> 1);
        sb1_in = {rej_in, baud_rate, clock_hz_reg};
    end

    logic              v1;
    logic [NUM1_W-1:0] q1;
    logic [SB1_W-1:0]  sb1_out;

    ubd_div_pipe #(.NUM_W(NUM1_W), .DEN_W(BAUD_W), .SB_W(SB1_W)) u_div_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .num      (num1),
        .den      (baud_rate),
        .sb_in    (sb1_in),
        .out_valid(v1),
        .quo      (q1),
        .sb_out   (sb1_out)
    );

    logic              rej1;
    logic [BAUD_W-1:0] baud1;
    logic [CLK_W-1:0]  clk1;
    logic [SB2_W-1:0]  sb2_in;
    logic [NUM2_W-1:0] num2;

    always_comb
    begin
        clk1   = sb1_out[CLK_W-1:0];
        baud1  = sb1_out[CLK_W +: BAUD_W];
        rej1   = sb1_out[SB1_W-1] || (q1 < DIV_MIN) || (q1 > DIV_MAX);
        num2   = {clk1, 2'b00};
        sb2_in = {rej1, baud1, q1[DIV_W-1:0]};
    end

    logic              v2;
    logic [NUM2_W-1:0] q2;
    logic [SB2_W-1:0]  sb2_out;

    ubd_div_pipe #(.NUM_W(NUM2_W), .DEN_W(DIV_W), .SB_W(SB2_W)) u_div_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1),
        .num      (num2),
        .den      (q1[DIV_W-1:0]),
        .sb_in    (sb2_in),
        .out_valid(v2),
        .quo      (q2),
        .sb_out   (sb2_out)
    );

    // error check: |achieved - baud| * 100 > baud * 2
    logic [BAUD_W-1:0]   baud2;
    logic [DIV_W-1:0]    dv2;
    logic [NUM2_W-1:0]   diff;
    logic [NUM2_W+6:0]   lhs;
    logic [NUM2_W+6:0]   rhs;
    logic                ok;

    always_comb
    begin
        baud2 = sb2_out[DIV_W +: BAUD_W];
        dv2   = sb2_out[DIV_W-1:0];
        diff  = (q2 > NUM2_W'(baud2)) ? q2 - NUM2_W'(baud2) : NUM2_W'(baud2) - q2;
        lhs   = (NUM2_W+7)'(diff) * (NUM2_W+7)'(PCT_SCALE);
        rhs   = (NUM2_W+7)'(baud2) * (NUM2_W+7)'(ERR_PCT);
        ok    = !sb2_out[SB2_W-1] && !(lhs > rhs);
    end

    logic             out_valid_reg;
    logic             valid_res_reg;
    logic [DIV_W-1:0] divisor_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_res_reg <= ok;
            divisor_reg   <= ok ? dv2 : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign divisor   = divisor_reg;

endmodule

/* src/ubd_checker.sv */
module ubd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        valid_res,
    input logic [21:0] divisor
);

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (divisor == 22'd0))
        else $error("rejected result with nonzero divisor");

    a_accept_min: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (divisor >= 22'd64))
        else $error("accepted divisor below minimum");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(divisor) && $stable(valid_res)))
        else $error("stalled result changed");

endmodule

bind uart_baud_divisor_check ubd_checker u_ubd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .valid_res(valid_res),
    .divisor  (divisor)
);
